@@ hw/rtl/ntm_pkg.sv @@
// Shared types and constants for the nearest track id matcher.
package ntm_pkg;

    localparam int unsigned POS_W    = 24;
    localparam int unsigned DIFF_W   = POS_W + 1;
    localparam int unsigned SQ_W     = 2 * DIFF_W;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned RAD_W    = 49;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 32;
    localparam int unsigned M_USER_W = 2;

    localparam logic [RAD_W-1:0] RADIUS_SQ_RST = RAD_W'(42949673);
    localparam logic [ID_W-1:0]  NEW_ID_RST    = ID_W'(1000);

    localparam logic OP_DETECT = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } t_entry;

    localparam int unsigned ENT_W = $bits(t_entry);

    typedef struct packed {
        logic            vld;
        logic            hit;
        logic [ID_W-1:0] id;
    } t_dist_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/ntm_track_mem.sv @@
// Track store: one write port, one read port, registered read data.
module ntm_track_mem #(
    parameter int unsigned ADDR_W = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [ntm_pkg::ENT_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [ntm_pkg::ENT_W-1:0] o_rdata
);
    import ntm_pkg::*;

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ntm_dist.sv @@
// Three-stage squared-distance pipeline: difference, square, sum and compare.
module ntm_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_flush,
    input  logic                            i_vld,
    input  logic signed [ntm_pkg::POS_W-1:0] i_px,
    input  logic signed [ntm_pkg::POS_W-1:0] i_py,
    input  ntm_pkg::t_entry                 i_entry,
    input  logic [ntm_pkg::RAD_W-1:0]       i_radius,
    output ntm_pkg::t_dist_res              o_res
);
    import ntm_pkg::*;

    logic                     r_a_vld;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [ID_W-1:0]          r_a_id;

    logic                     r_b_vld;
    logic signed [SQ_W-1:0]   r_sqx;
    logic signed [SQ_W-1:0]   r_sqy;
    logic [ID_W-1:0]          r_b_id;

    logic                     r_c_vld;
    logic                     r_c_hit;
    logic [ID_W-1:0]          r_c_id;

    logic signed [DIFF_W-1:0] n_dx;
    logic signed [DIFF_W-1:0] n_dy;
    logic signed [SQ_W-1:0]   n_sqx;
    logic signed [SQ_W-1:0]   n_sqy;
    logic [RAD_W:0]           n_sum;

    assign n_dx  = DIFF_W'(i_px) - DIFF_W'($signed(i_entry.x));
    assign n_dy  = DIFF_W'(i_py) - DIFF_W'($signed(i_entry.y));
    assign n_sqx = r_dx * r_dx;
    assign n_sqy = r_dy * r_dy;
    assign n_sum = {1'b0, r_sqx[RAD_W-1:0]} + {1'b0, r_sqy[RAD_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_a_id  <= i_entry.id;
        r_sqx   <= n_sqx;
        r_sqy   <= n_sqy;
        r_b_id  <= r_a_id;
        r_c_hit <= n_sum < {1'b0, i_radius};
        r_c_id  <= r_b_id;
    end

    assign o_res.vld = r_c_vld;
    assign o_res.hit = r_c_hit;
    assign o_res.id  = r_c_id;

endmodule

@@ hw/rtl/nearest_track_id_matcher_unit.sv @@
// Nearest track id matcher: banked track store, scan control and result register.
// Detection: scans the previous bank, one memory read a cycle, through the read
// register and three distance stages, stopping early on a match; an empty
// previous bank skips the scan. End of frame: no result. One item at a time.
// Reset (synchronous, active low) clears counts, bank select, id counter and
// radius; the track store is not cleared and holds nothing valid until written.
module nearest_track_id_matcher_unit #(
    parameter int unsigned MAX_TRACKS = 128
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ntm_pkg::RAD_W-1:0]       i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ntm_pkg::S_DATA_W-1:0]    s_axis_tdata,  // pos_x, pos_y
    input  logic [0:0]                      s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ntm_pkg::M_DATA_W-1:0]    m_axis_tdata,  // track_id
    output logic [ntm_pkg::M_USER_W-1:0]    m_axis_tuser   // matched, stored
);
    import ntm_pkg::*;

    localparam int unsigned IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned CNT_W  = $clog2(MAX_TRACKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS);

    t_state               r_state;
    t_state               n_state;
    logic                 r_bank;
    logic [CNT_W-1:0]     r_prev_cnt;
    logic [CNT_W-1:0]     r_cur_cnt;
    logic [ID_W-1:0]      r_next_id;
    logic [RAD_W-1:0]     r_radius;
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic [CNT_W-1:0]     r_iss;
    logic [CNT_W-1:0]     r_ret;
    logic                 r_rd_vld;
    logic                 r_hit;
    logic [ID_W-1:0]      r_id;
    logic                 r_m_vld;
    logic [ID_W-1:0]      r_m_id;
    logic                 r_m_match;
    logic                 r_m_stored;

    logic                 s_acc;
    logic                 rd_en;
    logic                 wr_en;
    logic                 out_load;
    logic                 flush;
    logic                 room;
    logic [ID_W-1:0]      fin_id;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    t_entry               wr_ent;
    t_entry               rd_ent;
    logic [ENT_W-1:0]     rd_data;
    t_dist_res            dres;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign flush         = (r_state != ST_SCAN);
    assign room          = r_cur_cnt < CNT_MAX;
    assign fin_id        = r_hit ? r_id : r_next_id;

    // reads hit the previous bank, writes the current one: never the same entry
    assign rd_addr = {~r_bank, r_iss[IDX_W-1:0]};
    assign wr_addr = {r_bank, r_cur_cnt[IDX_W-1:0]};
    assign wr_ent  = '{id: fin_id, y: r_py, x: r_px};
    assign rd_ent  = t_entry'(rd_data);

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && s_axis_tuser[0] == OP_DETECT) begin
                    n_state = (r_prev_cnt == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = (r_iss < r_prev_cnt);
                if (dres.vld && (dres.hit || r_ret == r_prev_cnt - CNT_W'(1))) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_m_vld || m_axis_tready) begin
                    out_load = 1'b1;
                    wr_en    = room;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= RADIUS_SQ_RST;
            r_bank     <= 1'b0;
            r_prev_cnt <= '0;
            r_cur_cnt  <= '0;
            r_next_id  <= NEW_ID_RST;
            r_rd_vld   <= 1'b0;
            r_m_vld    <= 1'b0;
            r_iss      <= '0;
            r_ret      <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
            r_rd_vld <= rd_en;
            if (s_acc) begin
                if (s_axis_tuser[0] == OP_EOF) begin
                    r_prev_cnt <= r_cur_cnt;
                    r_cur_cnt  <= '0;
                    r_bank     <= ~r_bank;
                end else begin
                    r_iss <= '0;
                    r_ret <= '0;
                    r_hit <= 1'b0;
                end
            end
            if (rd_en) begin
                r_iss <= r_iss + CNT_W'(1);
            end
            if (r_state == ST_SCAN && dres.vld) begin
                r_ret <= r_ret + CNT_W'(1);
                if (dres.hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (out_load) begin
                r_m_vld <= 1'b1;
                if (!r_hit) begin
                    r_next_id <= r_next_id + ID_W'(1);
                end
                if (room) begin
                    r_cur_cnt <= r_cur_cnt + CNT_W'(1);
                end
            end else if (m_axis_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px <= s_axis_tdata[POS_W-1:0];
            r_py <= s_axis_tdata[2*POS_W-1:POS_W];
        end
        if (r_state == ST_SCAN && dres.vld && dres.hit) begin
            r_id <= dres.id;
        end
        if (out_load) begin
            r_m_id     <= fin_id;
            r_m_match  <= r_hit;
            r_m_stored <= room;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_id;
    assign m_axis_tuser  = {r_m_stored, r_m_match};

    ntm_track_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_ent),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ntm_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flush  (flush),
        .i_vld    (r_rd_vld && !flush),
        .i_px     ($signed(r_px)),
        .i_py     ($signed(r_py)),
        .i_entry  (rd_ent),
        .i_radius (r_radius),
        .o_res    (dres)
    );

endmodule
